### rtl/fxalu_pkg.sv
package fxalu_pkg;

    localparam int FRAC_BITS_DEF  = 8;
    localparam int WORD_WIDTH_DEF = 32;
    localparam int PORT_W         = 32;
    localparam int MAG_W          = 32;
    localparam int INT_W          = 2 * MAG_W + 2;

    typedef enum logic [3:0] {
        MODE_ADD     = 4'd0,
        MODE_SUB     = 4'd1,
        MODE_MUL     = 4'd2,
        MODE_DIV     = 4'd3,
        MODE_INC     = 4'd4,
        MODE_DEC     = 4'd5,
        MODE_MIN     = 4'd6,
        MODE_MAX     = 4'd7,
        MODE_INT2FIX = 4'd8,
        MODE_FIX2INT = 4'd9
    } mode_t;

endpackage

### rtl/fixed_point_q24_8_alu.sv
// Channel | valid    | ready     | payload
// input   | in_valid | in_ready  | mode, operand_a, operand_b
// output  | out_valid| out_ready | result_value, compare flags, overflow_flag, divide_by_zero
//
// One item per cycle sustained unless the output stalls; 32 + FRAC_BITS + 4 register stages.
// The depth is set by the restoring divider, one quotient bit per stage.
// Reset clears the stage valid bits only.
// A stall at the output holds every stage; in_ready follows out_ready
// whenever the output stage is full.
module fixed_point_q24_8_alu
    import fxalu_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [3:0]               mode,
    input  logic signed [PORT_W-1:0] operand_a,
    input  logic signed [PORT_W-1:0] operand_b,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [PORT_W-1:0] result_value,
    output logic                     a_less_than_b,
    output logic                     a_equals_b,
    output logic                     a_greater_than_b,
    output logic                     overflow_flag,
    output logic                     divide_by_zero
);

    localparam int OPW  = (WORD_WIDTH < PORT_W) ? WORD_WIDTH : PORT_W;
    localparam int SH   = PORT_W - OPW;
    localparam int QW   = MAG_W + FRAC_BITS;
    localparam int NST  = QW + 4;
    localparam int RND  = QW + 2;
    localparam int LAST = NST - 1;
    localparam logic signed [INT_W-1:0] HI = (INT_W'(1) <<< (WORD_WIDTH - 1)) - INT_W'(1);
    localparam logic signed [INT_W-1:0] LO = -HI - INT_W'(1);
    localparam logic [2*MAG_W-1:0] HALF = (2*MAG_W)'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic                    vld;
        mode_t                   op;
        logic                    neg;
        logic                    lt;
        logic                    eq;
        logic                    gt;
        logic                    dbz;
        logic                    ovf;
        logic signed [INT_W-1:0] val;
        logic [MAG_W-1:0]        dvs;
        logic [QW-1:0]           num;
        logic [QW-1:0]           quo;
        logic [MAG_W-1:0]        rem;
        logic [2*MAG_W-1:0]      prod;
    } stage_t;

    stage_t pipe_reg  [NST];
    stage_t pipe_next [NST];
    logic   en;

    logic signed [PORT_W-1:0] a_trim;
    logic signed [PORT_W-1:0] b_trim;
    logic signed [INT_W-1:0]  a_s;
    logic signed [INT_W-1:0]  b_s;
    logic signed [INT_W-1:0]  a_abs;
    logic signed [INT_W-1:0]  b_abs;

    assign en       = !pipe_reg[LAST].vld || out_ready;
    assign in_ready = en;

    always_comb
    begin
        logic [MAG_W:0]          rem_sh;
        logic [MAG_W:0]          diff;
        logic                    qbit;
        logic [2*MAG_W-1:0]      pr;
        logic signed [INT_W-1:0] q;
        a_trim = $signed(operand_a <<< SH) >>> SH;
        b_trim = $signed(operand_b <<< SH) >>> SH;
        a_s    = INT_W'(a_trim);
        b_s    = INT_W'(b_trim);
        a_abs  = a_s[INT_W-1] ? -a_s : a_s;
        b_abs  = b_s[INT_W-1] ? -b_s : b_s;

        pipe_next[0]      = pipe_reg[0];
        pipe_next[0].vld  = in_valid;
        pipe_next[0].op   = mode_t'(mode);
        pipe_next[0].neg  = a_s[INT_W-1] ^ b_s[INT_W-1];
        pipe_next[0].lt   = a_s < b_s;
        pipe_next[0].eq   = a_s == b_s;
        pipe_next[0].gt   = a_s > b_s;
        pipe_next[0].dbz  = (mode_t'(mode) == MODE_DIV) && (b_s == '0);
        pipe_next[0].ovf  = 1'b0;
        pipe_next[0].dvs  = b_abs[MAG_W-1:0];
        pipe_next[0].num  = {a_abs[MAG_W-1:0], FRAC_BITS'(0)};
        pipe_next[0].quo  = '0;
        pipe_next[0].rem  = '0;
        pipe_next[0].prod = '0;
        unique case (mode_t'(mode))
            MODE_ADD:     pipe_next[0].val = a_s + b_s;
            MODE_SUB:     pipe_next[0].val = a_s - b_s;
            MODE_INC:     pipe_next[0].val = a_s + INT_W'(1);
            MODE_DEC:     pipe_next[0].val = a_s - INT_W'(1);
            MODE_MIN:     pipe_next[0].val = (a_s < b_s) ? a_s : b_s;
            MODE_MAX:     pipe_next[0].val = (a_s > b_s) ? a_s : b_s;
            MODE_INT2FIX: pipe_next[0].val = a_s <<< FRAC_BITS;
            MODE_FIX2INT: pipe_next[0].val = a_s >>> FRAC_BITS;
            default:      pipe_next[0].val = '0;
        endcase

        pipe_next[1]      = pipe_reg[0];
        pipe_next[1].prod = pipe_reg[0].num[QW-1:FRAC_BITS] * pipe_reg[0].dvs;

        for (int k = 2; k < RND; k++)
        begin
            pipe_next[k]     = pipe_reg[k-1];
            rem_sh           = {pipe_reg[k-1].rem, pipe_reg[k-1].num[QW-1]};
            diff             = rem_sh - {1'b0, pipe_reg[k-1].dvs};
            qbit             = rem_sh >= {1'b0, pipe_reg[k-1].dvs};
            pipe_next[k].rem = qbit ? diff[MAG_W-1:0] : rem_sh[MAG_W-1:0];
            pipe_next[k].num = pipe_reg[k-1].num << 1;
            pipe_next[k].quo = {pipe_reg[k-1].quo[QW-2:0], qbit};
        end

        pipe_next[RND] = pipe_reg[RND-1];
        pr = (pipe_reg[RND-1].prod + HALF) >> FRAC_BITS;
        if (pipe_reg[RND-1].op == MODE_MUL)
        begin
            q = INT_W'(pr);
            pipe_next[RND].val = pipe_reg[RND-1].neg ? -q : q;
        end
        else if (pipe_reg[RND-1].op == MODE_DIV)
        begin
            q = INT_W'(pipe_reg[RND-1].quo)
                + INT_W'({pipe_reg[RND-1].rem, 1'b0} >= {1'b0, pipe_reg[RND-1].dvs});
            if (pipe_reg[RND-1].dbz)
                pipe_next[RND].val = '0;
            else
                pipe_next[RND].val = pipe_reg[RND-1].neg ? -q : q;
        end
        else
        begin
            q = '0;
        end

        pipe_next[LAST] = pipe_reg[LAST-1];
        if (pipe_reg[LAST-1].val > HI)
        begin
            pipe_next[LAST].val = HI;
            pipe_next[LAST].ovf = 1'b1;
        end
        else if (pipe_reg[LAST-1].val < LO)
        begin
            pipe_next[LAST].val = LO;
            pipe_next[LAST].ovf = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
                pipe_reg[k].vld <= 1'b0;
        end
        else if (en)
        begin
            for (int k = 0; k < NST; k++)
                pipe_reg[k] <= pipe_next[k];
        end
    end

    assign out_valid        = pipe_reg[LAST].vld;
    assign result_value     = pipe_reg[LAST].val[PORT_W-1:0];
    assign a_less_than_b    = pipe_reg[LAST].lt;
    assign a_equals_b       = pipe_reg[LAST].eq;
    assign a_greater_than_b = pipe_reg[LAST].gt;
    assign overflow_flag    = pipe_reg[LAST].ovf;
    assign divide_by_zero   = pipe_reg[LAST].dbz;

endmodule
